FILE: src/rmth_pkg.sv
// Package for the two-heap running median: constants, types and codes.
`default_nettype none
package rmth_pkg;

  localparam int unsigned Capacity = 1024;
  localparam int unsigned DataW    = 32;
  localparam int unsigned MedW     = DataW + 1;

  typedef enum logic {
    HeapPush,
    HeapReplace
  } heap_op_e;

  typedef struct packed {
    logic                     start;
    heap_op_e                 op;
    logic signed [DataW-1:0]  value;
  } heap_cmd_t;

  typedef enum logic [2:0] {
    HsIdle,
    HsUpRd,
    HsUpCmp,
    HsDnChk,
    HsDnRdr,
    HsDnCmp,
    HsFin
  } heap_st_e;

  typedef enum logic [1:0] {
    TsIdle,
    TsRun,
    TsOut
  } top_st_e;

endpackage
`default_nettype wire

FILE: src/rmth_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module rmth_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 512,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

FILE: src/rmth_heap.sv
// One heap: RAM plus a hole-based sift-up / sift-down sequencer and cached top.
`default_nettype none
module rmth_heap #(
  parameter int unsigned Depth = 512,
  parameter bit          IsMax = 1'b1,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned SizeW = $clog2(Depth + 1)
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire rmth_pkg::heap_cmd_t                cmd_i,
  output logic                                    busy_o,
  output logic signed [rmth_pkg::DataW-1:0]       top_o,
  output logic        [SizeW-1:0]                 size_o
);

  localparam int unsigned XW = AddrW + 2;

  rmth_pkg::heap_st_e st_q, st_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [SizeW-1:0]  size_q, size_d;
  logic signed [rmth_pkg::DataW-1:0] val_q, val_d, lval_q, lval_d, top_q;
  logic signed [rmth_pkg::DataW-1:0] rdata, best_val;

  logic                         we;
  logic [AddrW-1:0]             waddr, raddr, par, best_addr;
  logic [rmth_pkg::DataW-1:0]   wdata, rdata_raw;
  logic [XW-1:0]                lx, rx, nx;
  logic                         r_ok;

  function automatic logic above(input logic signed [rmth_pkg::DataW-1:0] a,
                                 input logic signed [rmth_pkg::DataW-1:0] b);
    above = IsMax ? (a > b) : (a < b);
  endfunction

  rmth_ram #(.Width(rmth_pkg::DataW), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata = $signed(rdata_raw);
  assign par   = AddrW'((idx_q - AddrW'(1)) >> 1);
  assign lx    = {1'b0, idx_q, 1'b1};
  assign rx    = lx + XW'(1);
  assign nx    = XW'(size_q);
  assign r_ok  = rx < nx;

  always_comb begin
    if (r_ok && above(rdata, lval_q)) begin
      best_val  = rdata;
      best_addr = rx[AddrW-1:0];
    end else begin
      best_val  = lval_q;
      best_addr = lx[AddrW-1:0];
    end
  end

  always_comb begin
    st_d   = st_q;
    idx_d  = idx_q;
    size_d = size_q;
    val_d  = val_q;
    lval_d = lval_q;
    we     = 1'b0;
    waddr  = idx_q;
    wdata  = val_q;
    raddr  = par;
    unique case (st_q)
      rmth_pkg::HsIdle: begin
        if (cmd_i.start) begin
          val_d = cmd_i.value;
          if (cmd_i.op == rmth_pkg::HeapPush) begin
            idx_d  = size_q[AddrW-1:0];
            size_d = size_q + SizeW'(1);
            st_d   = (size_q == '0) ? rmth_pkg::HsFin : rmth_pkg::HsUpRd;
          end else begin
            idx_d = '0;
            st_d  = rmth_pkg::HsDnChk;
          end
        end
      end
      rmth_pkg::HsUpRd: begin
        raddr = par;
        st_d  = rmth_pkg::HsUpCmp;
      end
      rmth_pkg::HsUpCmp: begin
        if (above(val_q, rdata)) begin
          we    = 1'b1;
          wdata = rdata;
          idx_d = par;
          st_d  = (par == '0) ? rmth_pkg::HsFin : rmth_pkg::HsUpRd;
        end else begin
          st_d = rmth_pkg::HsFin;
        end
      end
      rmth_pkg::HsDnChk: begin
        raddr = lx[AddrW-1:0];
        st_d  = (lx >= nx) ? rmth_pkg::HsFin : rmth_pkg::HsDnRdr;
      end
      rmth_pkg::HsDnRdr: begin
        lval_d = rdata;
        raddr  = rx[AddrW-1:0];
        st_d   = rmth_pkg::HsDnCmp;
      end
      rmth_pkg::HsDnCmp: begin
        if (above(best_val, val_q)) begin
          we    = 1'b1;
          wdata = best_val;
          idx_d = best_addr;
          st_d  = rmth_pkg::HsDnChk;
        end else begin
          st_d = rmth_pkg::HsFin;
        end
      end
      rmth_pkg::HsFin: begin
        we   = 1'b1;
        st_d = rmth_pkg::HsIdle;
      end
      default: st_d = rmth_pkg::HsIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= rmth_pkg::HsIdle;
      size_q <= '0;
    end else begin
      st_q   <= st_d;
      size_q <= size_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    val_q  <= val_d;
    lval_q <= lval_d;
    if (we && waddr == '0) begin
      top_q <= $signed(wdata);
    end
  end

  assign busy_o = (st_q != rmth_pkg::HsIdle);
  assign top_o  = top_q;
  assign size_o = size_q;

endmodule
`default_nettype wire

FILE: src/running_median_two_heaps.sv
// Running median over two heaps in RAM, one median result per sample.
// Sequence: accept, heap sift in TsRun, result load in TsOut; the time is set by the sift-down
// loop (two child reads and a compare per level on one read port).
// Flow: the next sample is accepted in the cycle after the result loads; none is taken while busy.
// Both heaps sift in parallel; a full store skips the heaps and answers with dropped set.
// Reset: heap sizes cleared asynchronously, RAM contents left as they are.
`default_nettype none
module running_median_two_heaps #(
  parameter int unsigned Capacity = rmth_pkg::Capacity,
  localparam int unsigned LoDepth = (Capacity + 1) / 2,
  localparam int unsigned UpDepth = Capacity / 2,
  localparam int unsigned LoSzW   = $clog2(LoDepth + 1),
  localparam int unsigned UpSzW   = $clog2(UpDepth + 1),
  localparam int unsigned CntW    = $clog2(Capacity + 1)
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic signed [rmth_pkg::DataW-1:0]    sample_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [rmth_pkg::MedW-1:0]          median_times_two_o,
  output logic        [CntW-1:0]                    stored_count_o,
  output logic                                      dropped_o
);

  rmth_pkg::top_st_e   st_q, st_d;
  rmth_pkg::heap_cmd_t lo_cmd, up_cmd;
  logic lo_busy, up_busy, accept, load;
  logic signed [rmth_pkg::DataW-1:0] lo_top, up_top;
  logic [LoSzW-1:0] lo_size;
  logic [UpSzW-1:0] up_size;
  logic [CntW-1:0]  count;
  logic signed [rmth_pkg::MedW-1:0] med;
  logic drop_q, drop_d, out_valid_q;
  logic signed [rmth_pkg::MedW-1:0] med_q;
  logic [CntW-1:0]  cnt_q;
  logic             drop_out_q;

  rmth_heap #(.Depth(LoDepth), .IsMax(1'b1)) u_lower (
    .clk_i, .rst_ni, .cmd_i(lo_cmd), .busy_o(lo_busy), .top_o(lo_top), .size_o(lo_size)
  );

  rmth_heap #(.Depth(UpDepth), .IsMax(1'b0)) u_upper (
    .clk_i, .rst_ni, .cmd_i(up_cmd), .busy_o(up_busy), .top_o(up_top), .size_o(up_size)
  );

  assign count  = CntW'(lo_size) + CntW'(up_size);
  assign accept = in_valid_i && (st_q == rmth_pkg::TsIdle);

  always_comb begin
    if (count[0]) begin
      med = {lo_top[rmth_pkg::DataW-1], lo_top} <<< 1;
    end else if (up_size != '0) begin
      med = {lo_top[rmth_pkg::DataW-1], lo_top} + {up_top[rmth_pkg::DataW-1], up_top};
    end else begin
      med = '0;
    end
  end

  always_comb begin
    st_d   = st_q;
    drop_d = drop_q;
    load   = 1'b0;
    lo_cmd = '{start: 1'b0, op: rmth_pkg::HeapPush, value: sample_i};
    up_cmd = '{start: 1'b0, op: rmth_pkg::HeapPush, value: sample_i};
    unique case (st_q)
      rmth_pkg::TsIdle: begin
        if (accept) begin
          if (count == CntW'(Capacity)) begin
            drop_d = 1'b1;
            st_d   = rmth_pkg::TsOut;
          end else begin
            drop_d = 1'b0;
            st_d   = rmth_pkg::TsRun;
            if (lo_size == '0 || sample_i < lo_top) begin
              lo_cmd.start = 1'b1;
              if (CntW'(lo_size) == CntW'(up_size) + CntW'(1)) begin
                lo_cmd.op    = rmth_pkg::HeapReplace;
                up_cmd.start = 1'b1;
                up_cmd.value = lo_top;
              end
            end else if (CntW'(lo_size) == CntW'(up_size)) begin
              lo_cmd.start = 1'b1;
              if (!(up_size == '0 || sample_i <= up_top)) begin
                lo_cmd.value = up_top;
                up_cmd.start = 1'b1;
                up_cmd.op    = rmth_pkg::HeapReplace;
              end
            end else begin
              up_cmd.start = 1'b1;
            end
          end
        end
      end
      rmth_pkg::TsRun: begin
        if (!lo_busy && !up_busy) begin
          st_d = rmth_pkg::TsOut;
        end
      end
      rmth_pkg::TsOut: begin
        if (!out_valid_q || !out_stall_i) begin
          load = 1'b1;
          st_d = rmth_pkg::TsIdle;
        end
      end
      default: st_d = rmth_pkg::TsIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= rmth_pkg::TsIdle;
      out_valid_q <= 1'b0;
      drop_q      <= 1'b0;
    end else begin
      st_q        <= st_d;
      drop_q      <= drop_d;
      out_valid_q <= load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      med_q      <= med;
      cnt_q      <= count;
      drop_out_q <= drop_q;
    end
  end

  assign in_stall_o         = (st_q != rmth_pkg::TsIdle);
  assign out_valid_o        = out_valid_q;
  assign median_times_two_o = med_q;
  assign stored_count_o     = cnt_q;
  assign dropped_o          = drop_out_q;

endmodule
`default_nettype wire

FILE: sim/running_median_two_heaps_chk.sv
// Checker for the two-heap running median: watches both channels, predicts, compares.
`default_nettype none
module running_median_two_heaps_chk (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire logic signed [31:0] sample_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire logic signed [32:0] median_times_two_i,
  input  wire logic        [10:0] stored_count_i,
  input  wire logic               dropped_i,
  output int                      errors_o,
  output int                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HalfDepth = rmth_pkg::Capacity / 2;
  localparam int LoH = 0;
  localparam int UpH = 1;

  typedef struct {
    logic signed [32:0] med2;
    logic        [10:0] count;
    logic               drop;
  } median_res_t;

  longint      heaps [2][HalfDepth];
  int unsigned hsize [2];
  median_res_t median_q [$];

  // lower half orders as a max-heap, upper half as a min-heap
  function automatic bit outranks(longint a, longint b, int h);
    return (h == LoH) ? (a > b) : (a < b);
  endfunction

  function automatic void heap_push(int h, longint v);
    int unsigned i;
    int unsigned p;
    longint t;
    i = hsize[h];
    heaps[h][i] = v;
    hsize[h] = i + 1;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!outranks(heaps[h][i], heaps[h][p], h)) break;
      t = heaps[h][i]; heaps[h][i] = heaps[h][p]; heaps[h][p] = t;
      i = p;
    end
  endfunction

  function automatic void heap_swap_top(int h, longint v);
    int unsigned i;
    int unsigned l;
    int unsigned best;
    longint t;
    i = 0;
    heaps[h][0] = v;
    forever begin
      l = 2 * i + 1;
      best = i;
      if (l < hsize[h] && outranks(heaps[h][l], heaps[h][best], h)) best = l;
      if (l + 1 < hsize[h] && outranks(heaps[h][l+1], heaps[h][best], h)) best = l + 1;
      if (best == i) break;
      t = heaps[h][i]; heaps[h][i] = heaps[h][best]; heaps[h][best] = t;
      i = best;
    end
  endfunction

  function automatic median_res_t add_sample(longint s);
    median_res_t r;
    int unsigned n;
    r.drop = 1'b0;
    r.med2 = '0;
    if (hsize[LoH] + hsize[UpH] >= rmth_pkg::Capacity) begin
      r.drop = 1'b1;
    end else if (hsize[LoH] == 0 || s < heaps[LoH][0]) begin
      if (hsize[LoH] == hsize[UpH] + 1) begin
        heap_push(UpH, heaps[LoH][0]);
        heap_swap_top(LoH, s);
      end else begin
        heap_push(LoH, s);
      end
    end else if (hsize[LoH] == hsize[UpH]) begin
      if (hsize[UpH] == 0 || s <= heaps[UpH][0]) begin
        heap_push(LoH, s);
      end else begin
        heap_push(LoH, heaps[UpH][0]);
        heap_swap_top(UpH, s);
      end
    end else begin
      heap_push(UpH, s);
    end
    n = hsize[LoH] + hsize[UpH];
    if (n % 2 == 1) r.med2 = 33'(2 * heaps[LoH][0]);
    else if (hsize[UpH] != 0) r.med2 = 33'(heaps[LoH][0] + heaps[UpH][0]);
    r.count = 11'(n);
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  assign pending_o = median_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    median_res_t w;
    if (!rst_ni) begin
      hsize[LoH] = 0;
      hsize[UpH] = 0;
      median_q.delete();
      errors_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (median_q.size() == 0) begin
          report("unexpected item, count", stored_count_i, -1);
        end else begin
          w = median_q.pop_front();
          if (median_times_two_i !== w.med2) report("median_times_two", median_times_two_i, w.med2);
          if (stored_count_i !== w.count) report("stored_count", stored_count_i, w.count);
          if (dropped_i !== w.drop) report("dropped", dropped_i, w.drop);
        end
      end
      if (in_valid_i && !in_stall_i) median_q.push_back(add_sample(longint'(sample_i)));
    end
  end
endmodule
`default_nettype wire

FILE: sim/running_median_two_heaps_tb.sv
// Testbench top for the two-heap running median: clock, reset, stimulus and verdict.
`default_nettype none
module running_median_two_heaps_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom = 1430;
  localparam longint CycleLimit = 1000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] sample_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [32:0] median_times_two_o;
  logic        [10:0] stored_count_o;
  logic               dropped_o;
  int                 errors;
  int                 pending;
  longint             cycles = 0;
  bit                 sending_done = 1'b0;

  running_median_two_heaps dut (.*);

  running_median_two_heaps_chk chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .sample_i,
    .out_valid_i(out_valid_o), .out_stall_i, .median_times_two_i(median_times_two_o),
    .stored_count_i(stored_count_o), .dropped_i(dropped_o),
    .errors_o(errors), .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[running_median_two_heaps] ERROR");
      $finish;
    end
  end

  task automatic send_sample(logic signed [31:0] s);
    sample_i <= s;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 16) - 8;
      1: return 32'sh7FFF_FFF0 + $urandom_range(0, 15);
      2: return 32'sh8000_0000 + $urandom_range(0, 15);
      3: return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  // receiver: stall pattern changes per segment, one long hold-off early on
  initial begin
    int pct;
    int seg;
    repeat (8) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    out_stall_i <= 1'b1;
    repeat (400) @(posedge clk_i);
    forever begin
      case ($urandom_range(0, 3))
        0: pct = 0;
        1: pct = 30;
        2: pct = 70;
        default: pct = 95;
      endcase
      seg = $urandom_range(5, 200);
      repeat (seg) begin
        out_stall_i <= ($urandom_range(0, 99) < pct);
        @(posedge clk_i);
      end
    end
  end

  initial begin
    logic signed [31:0] directed [$];
    int burst;
    directed = '{32'sh0, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1, 32'sd1,
                 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                 32'sd5, 32'sd5, 32'sd5, -32'sd5, 32'sd0, 32'sd0, 32'sd3,
                 32'sd2, 32'sd4, -32'sd2, 32'sh5555_5555, 32'shAAAA_AAAA};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_sample(directed[i]);
    for (int n = 0; n < NumRandom; ) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && n < NumRandom; b++, n++) send_sample(pick_sample());
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    // let the checker record the last accepted item before draining
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("[running_median_two_heaps] OK");
    end else begin
      $display("[running_median_two_heaps] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: running_median_two_heaps.f
src/rmth_pkg.sv
src/rmth_ram.sv
src/rmth_heap.sv
src/running_median_two_heaps.sv
sim/running_median_two_heaps_chk.sv
sim/running_median_two_heaps_tb.sv
